### hw/rtl/sfs_pkg.sv
// Shared types, command codes and coil patterns for the full-step sequencer.
package sfs_pkg;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;
  localparam logic [1:0] MODE_KEEP = 2'd3;

  localparam logic [8:0] ELAPSED_MAX = 9'd511;
  localparam logic [3:0] COILS_OFF   = 4'b0000;

  typedef struct packed {
    logic [3:0]         coil_drive;
    logic               step_taken;
    logic               done_res;
    logic signed [15:0] steps_remaining;
  } sfs_res_t;

  // Coil levels (a1 a2 b1 b2) for each phase of the full-step cycle.
  function automatic logic [3:0] phase_pattern(input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0:    pat = 4'b1010;
      2'd1:    pat = 4'b0110;
      2'd2:    pat = 4'b0101;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/sfs_cmd_if.sv
// Command channel: valid/ready handshake carrying one sequencer command.
interface sfs_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] step_count;
  logic [7:0]         step_interval;

  modport source (output valid, mode, step_count, step_interval, input ready);
  modport sink (input valid, mode, step_count, step_interval, output ready);
endinterface

### hw/rtl/sfs_res_if.sv
// Result channel: valid/ready handshake carrying coil levels and step status.
interface sfs_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_drive;
  logic               step_taken;
  logic               done_res;
  logic signed [15:0] steps_remaining;

  modport source (output valid, coil_drive, step_taken, done_res, steps_remaining,
                  input ready);
  modport sink (input valid, coil_drive, step_taken, done_res, steps_remaining,
                output ready);
endinterface

### hw/rtl/sfs_core.sv
// Sequencer state and the per-command update of phase, count, timer and coils.
module sfs_core
  import sfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         mode,
  input  logic signed [15:0] step_count,
  input  logic [7:0]         step_interval,
  output sfs_res_t           result
);

  logic [1:0]  phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  interval, interval_next;
  logic [8:0]  elapsed, elapsed_next;
  logic [3:0]  coil_state, coil_state_next;

  logic [8:0]  elapsed_inc;
  logic        step_go;
  logic        taken;
  logic        done;

  assign elapsed_inc = (elapsed < ELAPSED_MAX) ? elapsed + 9'd1 : elapsed;
  assign step_go     = (remaining != 16'd0) && (elapsed_inc > {1'b0, interval});

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    interval_next   = interval;
    elapsed_next    = elapsed;
    coil_state_next = coil_state;
    taken           = 1'b0;
    done            = 1'b0;
    case (mode)
      MODE_TICK: begin
        elapsed_next = elapsed_inc;
        if (step_go) begin
          elapsed_next = 9'd0;
          taken        = 1'b1;
          // A negative count steps the phase backward and counts up to zero.
          if (remaining[15]) begin
            phase_next     = phase - 2'd1;
            remaining_next = remaining + 16'd1;
          end else begin
            phase_next     = phase + 2'd1;
            remaining_next = remaining - 16'd1;
          end
          coil_state_next = phase_pattern(phase_next);
          if (remaining_next == 16'd0) begin
            done            = 1'b1;
            coil_state_next = COILS_OFF;
          end
        end
      end
      MODE_MOVE: begin
        remaining_next = step_count;
        interval_next  = step_interval;
        elapsed_next   = 9'd0;
      end
      MODE_STOP: begin
        coil_state_next = COILS_OFF;
        remaining_next  = 16'd0;
      end
      default: begin
        coil_state_next = phase_pattern(phase);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 2'd0;
      remaining  <= 16'd0;
      interval   <= 8'd0;
      elapsed    <= 9'd0;
      coil_state <= COILS_OFF;
    end else if (accept) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      interval   <= interval_next;
      elapsed    <= elapsed_next;
      coil_state <= coil_state_next;
    end
  end

  assign result.coil_drive      = coil_state_next;
  assign result.step_taken      = taken;
  assign result.done_res        = done;
  assign result.steps_remaining = remaining_next;

endmodule

### hw/rtl/stepper_full_step_sequencer.sv
// Top level of the two-phase full-step stepper sequencer.
//
// The cmd channel takes one command per beat: tick, move, stop or keep.
// Every command beat yields exactly one beat on the res channel with the
// coil levels, step and done flags, and the signed count still to move.
// The sequencer state is updated in the cycle the command is accepted and
// the result lands in an output register, so a result appears in the cycle
// after its command, and a new command is taken in every cycle while results drain.
// The result register is the only buffer: cmd.ready is high while the
// register is empty or being emptied in the same cycle, so a stalled
// receiver holds the result steady and stops the command side until the
// beat is taken; no command or result is lost.
// Synchronous reset puts the motor at phase 0 with all coils off, no steps
// left, interval and elapsed time zero, and the result register empty.
module stepper_full_step_sequencer
  import sfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sfs_cmd_if.sink   cmd,
  sfs_res_if.source res
);

  logic     accept;
  sfs_res_t result;
  sfs_res_t res_q;
  logic     res_valid;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  sfs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .mode          (cmd.mode),
    .step_count    (cmd.step_count),
    .step_interval (cmd.step_interval),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign res.valid           = res_valid;
  assign res.coil_drive      = res_q.coil_drive;
  assign res.step_taken      = res_q.step_taken;
  assign res.done_res        = res_q.done_res;
  assign res.steps_remaining = res_q.steps_remaining;

`ifndef SYNTHESIS
  a_done_is_step: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res |-> res.step_taken)
    else $error("done without a step");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res |-> res.coil_drive == COILS_OFF && res.steps_remaining == 16'sd0)
    else $error("done with coils on or steps left");

  a_step_pattern: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.step_taken && !res.done_res |->
      res.coil_drive == 4'b1010 || res.coil_drive == 4'b0110 ||
      res.coil_drive == 4'b0101 || res.coil_drive == 4'b1001)
    else $error("step drove an invalid coil pattern");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.valid)
    else $error("accepted command produced no result");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the full-step stepper sequencer: command stimulus and result checks.
`timescale 1ns / 1ps

module tb_top;
  import sfs_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  sfs_cmd_if cmd_ch ();
  sfs_res_if res_ch ();

  stepper_full_step_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Motor state as the checker expects it to be after every accepted command.
  logic [1:0]         mot_phase;
  logic signed [15:0] mot_left;
  logic [7:0]         mot_ivl;
  logic [8:0]         mot_elapsed;
  logic [3:0]         mot_coils;

  logic [3:0] coil_of_phase [4] = '{4'b1010, 4'b0110, 4'b0101, 4'b1001};

  sfs_res_t motion_q[$];
  int       err_count = 0;
  int       items_sent = 0;
  bit       tx_gaps_on = 1'b0;
  bit       rx_gaps_on = 1'b0;
  bit       rx_hold = 1'b0;

  function automatic sfs_res_t advance_motor(input logic [1:0] mode,
                                             input logic signed [15:0] cnt,
                                             input logic [7:0] ivl);
    sfs_res_t r;
    r.step_taken = 1'b0;
    r.done_res   = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (mot_elapsed != ELAPSED_MAX) mot_elapsed = mot_elapsed + 9'd1;
        if (mot_left != 0 && mot_elapsed > {1'b0, mot_ivl}) begin
          mot_elapsed = '0;
          if (mot_left < 0) begin
            mot_phase = mot_phase - 2'd1;
            mot_left  = mot_left + 16'sd1;
          end else begin
            mot_phase = mot_phase + 2'd1;
            mot_left  = mot_left - 16'sd1;
          end
          mot_coils    = coil_of_phase[mot_phase];
          r.step_taken = 1'b1;
          if (mot_left == 0) begin
            r.done_res = 1'b1;
            mot_coils  = COILS_OFF;
          end
        end
      end
      MODE_MOVE: begin
        mot_left    = cnt;
        mot_ivl     = ivl;
        mot_elapsed = '0;
      end
      MODE_STOP: begin
        mot_coils = COILS_OFF;
        mot_left  = '0;
      end
      default: begin
        mot_coils = coil_of_phase[mot_phase];
      end
    endcase
    r.coil_drive      = mot_coils;
    r.steps_remaining = mot_left;
    return r;
  endfunction

  // Results are checked before the command of the same edge is predicted.
  always @(posedge clk) begin
    sfs_res_t want;
    if (rst) begin
      mot_phase   = '0;
      mot_left    = '0;
      mot_ivl     = '0;
      mot_elapsed = '0;
      mot_coils   = COILS_OFF;
      motion_q.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (motion_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result beat with no command pending: coils %b rem %0d",
                     $realtime, res_ch.coil_drive, res_ch.steps_remaining);
        end else begin
          want = motion_q.pop_front();
          if (res_ch.coil_drive !== want.coil_drive ||
              res_ch.step_taken !== want.step_taken ||
              res_ch.done_res !== want.done_res ||
              res_ch.steps_remaining !== want.steps_remaining) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch, expected coils %b taken %b done %b rem %0d,",
                        " got coils %b taken %b done %b rem %0d"}, $realtime,
                       want.coil_drive, want.step_taken, want.done_res,
                       want.steps_remaining, res_ch.coil_drive, res_ch.step_taken,
                       res_ch.done_res, res_ch.steps_remaining);
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        motion_q.push_back(advance_motor(cmd_ch.mode, cmd_ch.step_count,
                                         cmd_ch.step_interval));
    end
  end

  // Receiver side: random stall bursts, plus one long hold on request.
  initial begin : res_ready_drive
    int burst;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        res_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one command beat and returns at the edge where it is taken.
  task automatic send_cmd(input logic [1:0] mode, input logic signed [15:0] cnt,
                          input logic [7:0] ivl);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.mode          <= mode;
    cmd_ch.step_count    <= cnt;
    cmd_ch.step_interval <= ivl;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_noise();
    send_cmd(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
  endtask

  // Sampled at the falling edge, after the checker has settled.
  task automatic wait_all_results();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (motion_q.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  function automatic logic [7:0] pick_interval();
    case ($urandom_range(0, 19))
      0:             return 8'($urandom_range(0, 255));
      1, 2, 3, 4, 5: return 8'($urandom_range(0, 15));
      default:       return 8'($urandom_range(0, 3));
    endcase
  endfunction

  // A move, then at most 300 mostly-tick commands to run it out; or else a burst of random commands.
  task automatic run_move_sequence();
    logic signed [15:0] cnt;
    logic [7:0]         ivl;
    int                 n;
    int                 mag;
    int                 pick;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 10);
      repeat (n) send_noise();
    end else begin
      cnt = pick_count();
      ivl = pick_interval();
      send_cmd(MODE_MOVE, cnt, ivl);
      mag = (cnt < 0) ? -int'(cnt) : int'(cnt);
      n = mag * (int'(ivl) + 1) + $urandom_range(0, 3);
      if (n > 300) n = $urandom_range(40, 300);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) send_cmd(MODE_KEEP, 16'($urandom), 8'($urandom));
        else if (pick < 6) send_cmd(MODE_STOP, 16'($urandom), 8'($urandom));
        else if (pick < 8) send_cmd(MODE_MOVE, pick_count(), pick_interval());
        else send_cmd(MODE_TICK, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_idle_commands();
    send_cmd(MODE_KEEP, 16'sd0, 8'd0);
    send_cmd(MODE_TICK, 16'sd5, 8'd9);
    send_cmd(MODE_STOP, 16'sd0, 8'd0);
    send_cmd(MODE_KEEP, -16'sd1, 8'hFF);
  endtask

  task automatic test_short_moves();
    send_cmd(MODE_MOVE, 16'sd2, 8'd0);
    repeat (2) send_cmd(MODE_TICK, 16'sd0, 8'd0);
    send_cmd(MODE_MOVE, -16'sd3, 8'd1);
    send_cmd(MODE_TICK, 16'sd0, 8'd0);
    send_cmd(MODE_TICK, 16'sd0, 8'd0);
    send_cmd(MODE_KEEP, 16'sd0, 8'd0);
    repeat (4) send_cmd(MODE_TICK, 16'sd0, 8'd0);
    // A zero-length move reloads the interval but must never step.
    send_cmd(MODE_MOVE, 16'sd0, 8'd0);
    send_cmd(MODE_TICK, 16'sd0, 8'd0);
  endtask

  task automatic test_count_extremes();
    send_cmd(MODE_MOVE, 16'sh8000, 8'd0);
    send_cmd(MODE_TICK, 16'sd0, 8'd0);
    send_cmd(MODE_STOP, 16'sd0, 8'd0);
    send_cmd(MODE_MOVE, 16'sh7FFF, 8'hFF);
    send_cmd(MODE_TICK, 16'sd0, 8'd0);
    send_cmd(MODE_STOP, 16'sd0, 8'd0);
    send_cmd(MODE_KEEP, 16'sd0, 8'd0);
  endtask

  // Stop keeps elapsed, so a long run of ticks drives it into saturation.
  task automatic test_elapsed_saturation();
    send_cmd(MODE_MOVE, 16'sd1, 8'hFF);
    send_cmd(MODE_STOP, 16'sd0, 8'd0);
    repeat (520) send_cmd(MODE_TICK, 16'($urandom), 8'($urandom));
    send_cmd(MODE_KEEP, 16'sd0, 8'd0);
  endtask

  task automatic test_random_moves(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 3) == 0) begin
        tx_gaps_on = $urandom_range(0, 1);
        rx_gaps_on = $urandom_range(0, 1);
      end
      run_move_sequence();
    end
  endtask

  task automatic test_result_backpressure();
    rx_hold = 1'b1;
    repeat (5) run_move_sequence();
    wait_all_results();
  endtask

  task automatic test_no_idling(input int upto);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (items_sent < upto) run_move_sequence();
  endtask

  initial begin
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.mode          = MODE_KEEP;
    cmd_ch.step_count    = '0;
    cmd_ch.step_interval = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_short_moves();
    test_count_extremes();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_elapsed_saturation();
    test_random_moves(800);
    wait_all_results();
    test_result_backpressure();
    test_random_moves(1050);
    test_no_idling(1250);

    wait_all_results();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
